FILE: rtl/core/hermite_polynomial_eval_core_assert.svh
// Assertion macros for the Hermite polynomial evaluator core.
// No dependencies; included by modules that carry concurrent checks.
`ifndef HERMITE_POLYNOMIAL_EVAL_CORE_ASSERT_SVH
`define HERMITE_POLYNOMIAL_EVAL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define HPE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define HPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HPE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HPE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/hpe_pkg.sv
// Package for the Hermite polynomial evaluator: widths, constants, stage types.
// No dependencies.
`default_nettype none
package hpe_pkg;
    localparam int MAX_ORDER = 31;
    localparam int NUM_STEPS = MAX_ORDER - 1;
    localparam int ORD_W     = 5;
    localparam int X_W       = 16;
    localparam int V_W       = 48;
    localparam int PROD_W    = X_W + V_W;
    localparam int MA_W      = V_W + 7;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_SH   = 12;
    localparam int DIFF_W    = SUM_W - FRAC_SH + 2;

    localparam logic signed [V_W-1:0] ONE_Q16 = 48'sd65536;
    localparam logic signed [V_W-1:0] SAT_MAX = {1'b0, {(V_W-1){1'b1}}};
    localparam logic signed [V_W-1:0] SAT_MIN = {1'b1, {(V_W-1){1'b0}}};

    // Data carried between recurrence steps.
    typedef struct packed {
        logic                    valid;
        logic [ORD_W-1:0]        order;
        logic signed [X_W-1:0]   xr;
        logic signed [X_W-1:0]   xi;
        logic signed [V_W-1:0]   a_re;
        logic signed [V_W-1:0]   a_im;
        logic signed [V_W-1:0]   b_re;
        logic signed [V_W-1:0]   b_im;
        logic                    ovf;
    } t_step;

    // Data after the multiply half of a step.
    typedef struct packed {
        logic                     valid;
        logic [ORD_W-1:0]         order;
        logic signed [X_W-1:0]    xr;
        logic signed [X_W-1:0]    xi;
        logic signed [V_W-1:0]    b_re;
        logic signed [V_W-1:0]    b_im;
        logic signed [PROD_W-1:0] p_rr;
        logic signed [PROD_W-1:0] p_ii;
        logic signed [PROD_W-1:0] p_ri;
        logic signed [PROD_W-1:0] p_ir;
        logic signed [MA_W-1:0]   ma_re;
        logic signed [MA_W-1:0]   ma_im;
        logic                     ovf;
    } t_prod;

    // Clamp to 48 bits; top bit of the result is the saturation flag.
    function automatic logic [V_W:0] sat48(input logic signed [DIFF_W:0] v);
        logic [V_W:0] res;
        if (v > (DIFF_W+1)'(SAT_MAX)) begin
            res = {1'b1, SAT_MAX};
        end else if (v < (DIFF_W+1)'(SAT_MIN)) begin
            res = {1'b1, SAT_MIN};
        end else begin
            res = {1'b0, v[V_W-1:0]};
        end
        return res;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/hermite_polynomial_eval_core.sv
// Top level of the Hermite polynomial evaluator: fully unrolled recurrence pipeline.
// Depends on hpe_pkg and hermite_polynomial_eval_core_assert.svh.
// The pipeline has 1 + 2*(MAX_ORDER-1) = 61 register stages: the seed stage, loaded on
// the accepting edge, then a multiply and a combine stage for each recurrence step.
// Throughput: one item per cycle; every recurrence step owns a two-stage slice
// (complex multiply, then subtract/double/saturate), so items never share a unit.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) clears every valid bit; payload is not reset.
`default_nettype none
`include "hermite_polynomial_eval_core_assert.svh"
module hermite_polynomial_eval_core
    import hpe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // order[4:0], x_re[20:5], x_im[36:21], zero pad [39:37]
    input  wire logic [39:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // value_re[47:0], value_im[95:48]
    output logic [95:0]      o_m_tdata,
    // overflow[0]
    output logic [0:0]       o_m_tuser
);
    t_step r_in;
    t_prod r_a [NUM_STEPS];
    t_step r_b [NUM_STEPS];
    t_prod n_a [NUM_STEPS];
    t_step n_b [NUM_STEPS];
    t_step n_in;
    logic  w_en;

    // Advance everything whenever the output slot is free or being taken.
    assign w_en       = !r_b[NUM_STEPS-1].valid || i_m_tready;
    assign o_s_tready = w_en;

    // Seed: a = H_0 = 1, b = H_1 = 2x (Q3.12 -> Q31.16 is *16, doubled *32).
    // Order zero seeds b with 1.0 so the result is always the final b.
    always_comb begin
        n_in.valid = i_s_tvalid;
        n_in.order = i_s_tdata[4:0];
        n_in.xr    = i_s_tdata[20:5];
        n_in.xi    = i_s_tdata[36:21];
        n_in.a_re  = ONE_Q16;
        n_in.a_im  = '0;
        n_in.ovf   = 1'b0;
        if (n_in.order == '0) begin
            n_in.b_re = ONE_Q16;
            n_in.b_im = '0;
        end else begin
            n_in.b_re = V_W'(n_in.xr) <<< 5;
            n_in.b_im = V_W'(n_in.xi) <<< 5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in <= n_in;
        end
    end

    for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
        localparam logic signed [6:0] MULT = 7'(s + 1);
        localparam logic [ORD_W-1:0]  STEP_K = ORD_W'(s + 2);
        t_step w_src;
        logic signed [SUM_W-1:0]    w_sum_re;
        logic signed [SUM_W-1:0]    w_sum_im;
        logic signed [DIFF_W:0]     w_nr;
        logic signed [DIFF_W:0]     w_ni;
        logic [V_W:0]               w_sr;
        logic [V_W:0]               w_si;

        if (s == 0) begin : g_first
            assign w_src = r_in;
        end else begin : g_next
            assign w_src = r_b[s-1];
        end

        // Multiply half: x*b components and (k-1)*a.
        always_comb begin
            n_a[s].valid = w_src.valid;
            n_a[s].order = w_src.order;
            n_a[s].xr    = w_src.xr;
            n_a[s].xi    = w_src.xi;
            n_a[s].b_re  = w_src.b_re;
            n_a[s].b_im  = w_src.b_im;
            n_a[s].ovf   = w_src.ovf;
            n_a[s].p_rr  = PROD_W'(w_src.xr) * PROD_W'(w_src.b_re);
            n_a[s].p_ii  = PROD_W'(w_src.xi) * PROD_W'(w_src.b_im);
            n_a[s].p_ri  = PROD_W'(w_src.xr) * PROD_W'(w_src.b_im);
            n_a[s].p_ir  = PROD_W'(w_src.xi) * PROD_W'(w_src.b_re);
            n_a[s].ma_re = MA_W'(MULT) * MA_W'(w_src.a_re);
            n_a[s].ma_im = MA_W'(MULT) * MA_W'(w_src.a_im);
        end

        // Combine half: floor to Q31.16, subtract, double, saturate; past the order, hold b.
        always_comb begin
            w_sum_re = SUM_W'(r_a[s].p_rr) - SUM_W'(r_a[s].p_ii);
            w_sum_im = SUM_W'(r_a[s].p_ri) + SUM_W'(r_a[s].p_ir);
            w_nr = ((DIFF_W+1)'($signed(w_sum_re[SUM_W-1:FRAC_SH]))
                    - (DIFF_W+1)'(r_a[s].ma_re)) <<< 1;
            w_ni = ((DIFF_W+1)'($signed(w_sum_im[SUM_W-1:FRAC_SH]))
                    - (DIFF_W+1)'(r_a[s].ma_im)) <<< 1;
            w_sr = sat48(w_nr);
            w_si = sat48(w_ni);
            n_b[s].valid = r_a[s].valid;
            n_b[s].order = r_a[s].order;
            n_b[s].xr    = r_a[s].xr;
            n_b[s].xi    = r_a[s].xi;
            if (r_a[s].order < STEP_K) begin
                // Order already reached: hold b, a no longer matters.
                n_b[s].a_re = r_a[s].b_re;
                n_b[s].a_im = r_a[s].b_im;
                n_b[s].b_re = r_a[s].b_re;
                n_b[s].b_im = r_a[s].b_im;
                n_b[s].ovf  = r_a[s].ovf;
            end else begin
                n_b[s].a_re = r_a[s].b_re;
                n_b[s].a_im = r_a[s].b_im;
                n_b[s].b_re = w_sr[V_W-1:0];
                n_b[s].b_im = w_si[V_W-1:0];
                n_b[s].ovf  = r_a[s].ovf | w_sr[V_W] | w_si[V_W];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a[s].valid <= 1'b0;
                r_b[s].valid <= 1'b0;
            end else if (w_en) begin
                r_a[s] <= n_a[s];
                r_b[s] <= n_b[s];
            end
        end
    end

    assign o_m_tvalid = r_b[NUM_STEPS-1].valid;
    assign o_m_tdata  = {r_b[NUM_STEPS-1].b_im, r_b[NUM_STEPS-1].b_re};
    assign o_m_tuser  = r_b[NUM_STEPS-1].ovf;

    // An accepted item lands in the seed stage.
    `HPE_ASSERT_NEXT(a_seed_load, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_in.valid)
    // A stalled pipeline keeps its last stage.
    `HPE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_b[NUM_STEPS-1]))
    // A real argument gives a real result.
    `HPE_ASSERT_IMPL(a_real_arg, i_clk, i_rst_n,
        r_b[NUM_STEPS-1].valid && (r_b[NUM_STEPS-1].xi == '0), o_m_tdata[95:48] == '0)
endmodule
`default_nettype wire
